FILE: hdl/vrp_route_split_cost_core_assert.svh
// Assertion macros for the route split cost core.
// Depends on nothing; files that assert include it by name.
`ifndef VRP_ROUTE_SPLIT_COST_CORE_ASSERT_SVH
`define VRP_ROUTE_SPLIT_COST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define VRP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VRP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VRP_ASSERT_IMP(label, ante, cons)
`define VRP_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: hdl/vrp_rsc_pkg.sv
// Shared types, constants and helpers of the route split cost core.
// Depends on nothing.
package vrp_rsc_pkg;
    localparam int NODE_COUNT   = 64;
    localparam int DIST_BITS    = 20;
    localparam int NODE_BITS    = $clog2(NODE_COUNT);
    localparam int ADDR_BITS    = 2 * NODE_BITS;
    localparam int DEM_BITS     = 16;
    localparam int COST_BITS    = 32;
    localparam int ROUTE_BITS   = 7;
    localparam int TIME_BITS    = 20;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 20;

    typedef logic [NODE_BITS-1:0] t_node;
    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [DIST_BITS-1:0] t_dist;
    typedef logic [DEM_BITS-1:0]  t_dem;

    typedef enum logic [1:0] {
        CMD_LOAD_DIST   = 2'd0,
        CMD_LOAD_DEMAND = 2'd1,
        CMD_VISIT       = 2'd2,
        CMD_FINISH      = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_BITS-1:0] CFG_VEHICLE_CAPACITY = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ROUTE_TIME   = CFG_IDX_BITS'(1);

    typedef struct packed {
        logic decide;
        logic was_open;
        logic fin_fire;
        logic fin_open;
    } t_eval_ctl;

    function automatic t_addr dist_addr(t_node a, t_node b);
        return {a, b};
    endfunction
endpackage

FILE: hdl/vrp_rsc_dist_mem.sv
// Node-to-node distance memory: one write port, two registered read ports.
// Depends on vrp_rsc_pkg.
module vrp_rsc_dist_mem
    import vrp_rsc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_we,
    input  t_addr i_waddr,
    input  t_dist i_wdata,
    input  logic  i_re0,
    input  t_addr i_raddr0,
    input  logic  i_re1,
    input  t_addr i_raddr1,
    output t_dist o_rdata0,
    output t_dist o_rdata1
);
    t_dist r_mem [NODE_COUNT*NODE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re0) begin
            o_rdata0 <= r_mem[i_raddr0];
        end
        if (i_re1) begin
            o_rdata1 <= r_mem[i_raddr1];
        end
    end
endmodule

FILE: hdl/vrp_rsc_dem_mem.sv
// Per-node demand memory with one write port and one registered read port.
// Depends on vrp_rsc_pkg.
module vrp_rsc_dem_mem
    import vrp_rsc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_we,
    input  t_node i_waddr,
    input  t_dem  i_wdata,
    input  logic  i_re,
    input  t_node i_raddr,
    output t_dem  o_rdata
);
    t_dem r_mem [NODE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

FILE: hdl/vrp_rsc_eval.sv
// Split decision and per-order state: route length, load left, cost and count.
// Depends on vrp_rsc_pkg.
module vrp_rsc_eval
    import vrp_rsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_eval_ctl             i_ctl,
    input  t_dist                 i_hop,
    input  t_dist                 i_to_cust,
    input  t_dist                 i_cust_ret,
    input  t_dist                 i_last_ret,
    input  t_dem                  i_demand,
    input  t_dem                  i_capacity,
    input  logic [TIME_BITS-1:0]  i_max_time,
    output logic [COST_BITS-1:0]  o_fin_cost,
    output logic [ROUTE_BITS-1:0] o_fin_routes
);
    localparam logic [ROUTE_BITS-1:0] ROUTES_MAX = '1;

    t_dist                 r_route_len, n_route_len;
    t_dem                  r_load_left, n_load_left;
    logic [COST_BITS-1:0]  r_cost, n_cost;
    logic [ROUTE_BITS-1:0] r_routes, n_routes;

    logic [DIST_BITS+1:0]  w_trip;
    logic [DIST_BITS:0]    w_via;
    logic [DIST_BITS:0]    w_close_add;
    logic [DIST_BITS:0]    w_cont_len;
    logic [COST_BITS:0]    w_cost_sum;
    logic [COST_BITS-1:0]  w_cost_closed;
    logic [ROUTE_BITS-1:0] w_routes_closed;
    logic                  w_split;
    t_dem                  w_open_load;

    always_comb begin
        w_trip = (DIST_BITS+2)'(r_route_len) + (DIST_BITS+2)'(i_hop)
               + (DIST_BITS+2)'(i_cust_ret);
        w_via = (DIST_BITS+1)'(i_last_ret) + (DIST_BITS+1)'(i_to_cust);
        w_split = (w_trip > (DIST_BITS+2)'(i_max_time))
               || (i_demand > r_load_left)
               || (w_via < (DIST_BITS+1)'(i_hop));
        w_close_add = (DIST_BITS+1)'(r_route_len) + (DIST_BITS+1)'(i_last_ret);
        w_cost_sum = (COST_BITS+1)'(r_cost) + (COST_BITS+1)'(w_close_add);
        w_cost_closed = w_cost_sum[COST_BITS] ? '1 : w_cost_sum[COST_BITS-1:0];
        w_routes_closed = (r_routes == ROUTES_MAX) ? r_routes : r_routes + 1'b1;
        w_cont_len = (DIST_BITS+1)'(r_route_len) + (DIST_BITS+1)'(i_hop);
        w_open_load = (i_demand > i_capacity) ? '0 : i_capacity - i_demand;

        n_route_len = r_route_len;
        n_load_left = r_load_left;
        n_cost      = r_cost;
        n_routes    = r_routes;

        if (i_ctl.decide) begin
            if (!i_ctl.was_open || w_split) begin
                if (i_ctl.was_open) begin
                    n_cost   = w_cost_closed;
                    n_routes = w_routes_closed;
                end
                n_route_len = i_to_cust;
                n_load_left = w_open_load;
            end else begin
                n_route_len = w_cont_len[DIST_BITS] ? '1 : w_cont_len[DIST_BITS-1:0];
                n_load_left = r_load_left - i_demand;
            end
        end else if (i_ctl.fin_fire) begin
            n_route_len = '0;
            n_load_left = i_capacity;
            n_cost      = '0;
            n_routes    = '0;
        end

        o_fin_cost   = i_ctl.fin_open ? w_cost_closed : r_cost;
        o_fin_routes = i_ctl.fin_open ? w_routes_closed : r_routes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route_len <= '0;
            r_load_left <= '0;
            r_cost      <= '0;
            r_routes    <= '0;
        end else begin
            r_route_len <= n_route_len;
            r_load_left <= n_load_left;
            r_cost      <= n_cost;
            r_routes    <= n_routes;
        end
    end
endmodule

FILE: hdl/vrp_route_split_cost_core.sv
// Top level of the route split cost core: handshakes, configuration, sequencing.
// Depends on vrp_rsc_pkg, vrp_rsc_dist_mem, vrp_rsc_dem_mem and vrp_rsc_eval.
// Load beats may follow back to back. When a visit beat is taken, the two distance memory
// read ports fetch the hop and the return leg of the new customer; then, while r_s1_valid
// holds off input, they fetch the depot leg of the new customer and the return leg of the
// previous one, and the split decision follows while the next beat is taken. A finish beat
// fetches the return leg of the last customer; the order is closed in the next cycle and
// the result is offered in the cycle after that. A finish waits while the order before it
// is being closed or its result is still held; loads and visits go on meanwhile.
// The memories have no reset and need no clearing pass.
module vrp_route_split_cost_core
    import vrp_rsc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_cmd,
    input  logic [5:0]               i_from_node,
    input  logic [5:0]               i_to_node,
    input  logic [19:0]              i_distance_value,
    input  logic [15:0]              i_demand_value,
    input  logic [5:0]               i_customer,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [31:0]              o_total_cost,
    output logic [6:0]               o_route_count
);
    `include "vrp_route_split_cost_core_assert.svh"

    t_dem                  r_capacity;
    logic [TIME_BITS-1:0]  r_max_time;
    t_node                 r_last_node;
    logic                  r_s1_valid;
    t_node                 r_s1_cust;
    t_node                 r_s1_prev;
    logic                  r_s1_open;
    logic                  r_s2_valid;
    logic                  r_s2_open;
    logic                  r_fin_pend;
    logic                  r_fin_open;
    t_dist                 r_hop;
    t_dist                 r_cust_ret;
    logic                  r_out_valid;
    logic [COST_BITS-1:0]  r_out_cost;
    logic [ROUTE_BITS-1:0] r_out_routes;

    logic                  w_acc;
    logic                  w_from_ok;
    logic                  w_to_ok;
    logic                  w_cust_ok;
    logic                  w_visit;
    logic                  w_finish;
    logic                  w_fin_fire;
    logic                  w_fin_block;
    t_node                 w_from;
    t_node                 w_to;
    t_node                 w_cust;
    logic                  w_dist_we;
    logic                  w_dem_we;
    logic                  w_re0;
    t_addr                 w_raddr0;
    logic                  w_re1;
    t_addr                 w_raddr1;
    t_dist                 w_rdata0;
    t_dist                 w_rdata1;
    t_dem                  w_demand;
    t_eval_ctl             w_ctl;
    logic [COST_BITS-1:0]  w_fin_cost;
    logic [ROUTE_BITS-1:0] w_fin_routes;

    assign o_cfg_ready   = 1'b1;
    assign w_fin_block   = r_fin_pend || r_out_valid;
    assign o_in_ready    = !r_s1_valid && !(w_fin_block && (t_cmd'(i_cmd) == CMD_FINISH));
    assign o_out_valid   = r_out_valid;
    assign o_total_cost  = r_out_cost;
    assign o_route_count = r_out_routes;

    always_comb begin
        w_acc     = i_in_valid && o_in_ready;
        w_from    = NODE_BITS'(i_from_node);
        w_to      = NODE_BITS'(i_to_node);
        w_cust    = NODE_BITS'(i_customer);
        w_from_ok = int'(i_from_node) < NODE_COUNT;
        w_to_ok   = int'(i_to_node) < NODE_COUNT;
        w_cust_ok = (i_customer != '0) && (int'(i_customer) < NODE_COUNT);
        w_dist_we = 1'b0;
        w_dem_we  = 1'b0;
        w_visit   = 1'b0;
        w_finish  = 1'b0;
        if (w_acc) begin
            case (t_cmd'(i_cmd))
                CMD_LOAD_DIST:   w_dist_we = w_from_ok && w_to_ok;
                CMD_LOAD_DEMAND: w_dem_we  = w_to_ok;
                CMD_VISIT:       w_visit   = w_cust_ok;
                CMD_FINISH:      w_finish  = 1'b1;
                default:         w_finish  = 1'b0;
            endcase
        end
        w_re0    = w_visit || r_s1_valid;
        w_raddr0 = r_s1_valid ? dist_addr('0, r_s1_cust) : dist_addr(r_last_node, w_cust);
        w_re1    = w_visit || r_s1_valid || w_finish;
        if (w_visit) begin
            w_raddr1 = dist_addr(w_cust, '0);
        end else if (r_s1_valid) begin
            w_raddr1 = dist_addr(r_s1_prev, '0);
        end else begin
            w_raddr1 = dist_addr(r_last_node, '0);
        end
        w_fin_fire = r_fin_pend;
        w_ctl.decide   = r_s2_valid;
        w_ctl.was_open = r_s2_open;
        w_ctl.fin_fire = w_fin_fire;
        w_ctl.fin_open = r_fin_open;
    end

    vrp_rsc_dist_mem u_dist_mem (
        .i_clk    (i_clk),
        .i_we     (w_dist_we),
        .i_waddr  (dist_addr(w_from, w_to)),
        .i_wdata  (DIST_BITS'(i_distance_value)),
        .i_re0    (w_re0),
        .i_raddr0 (w_raddr0),
        .i_re1    (w_re1),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_rdata0),
        .o_rdata1 (w_rdata1)
    );

    vrp_rsc_dem_mem u_dem_mem (
        .i_clk   (i_clk),
        .i_we    (w_dem_we),
        .i_waddr (w_to),
        .i_wdata (i_demand_value),
        .i_re    (w_visit),
        .i_raddr (w_cust),
        .o_rdata (w_demand)
    );

    vrp_rsc_eval u_eval (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_hop        (r_hop),
        .i_to_cust    (w_rdata0),
        .i_cust_ret   (r_cust_ret),
        .i_last_ret   (w_rdata1),
        .i_demand     (w_demand),
        .i_capacity   (r_capacity),
        .i_max_time   (r_max_time),
        .o_fin_cost   (w_fin_cost),
        .o_fin_routes (w_fin_routes)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= '0;
            r_max_time  <= '1;
            r_last_node <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_fin_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_VEHICLE_CAPACITY) begin
                    r_capacity <= DEM_BITS'(i_cfg_data);
                end else if (i_cfg_index == CFG_MAX_ROUTE_TIME) begin
                    r_max_time <= TIME_BITS'(i_cfg_data);
                end
            end
            if (w_visit) begin
                r_last_node <= w_cust;
            end else if (w_finish) begin
                r_last_node <= '0;
            end
            r_s1_valid <= w_visit;
            r_s2_valid <= r_s1_valid;
            r_fin_pend <= w_finish;
            if (w_fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_visit) begin
            r_s1_cust <= w_cust;
            r_s1_prev <= r_last_node;
            r_s1_open <= r_last_node != '0;
        end
        if (w_finish) begin
            r_fin_open <= r_last_node != '0;
        end
        if (r_s1_valid) begin
            r_hop      <= w_rdata0;
            r_cust_ret <= w_rdata1;
            r_s2_open  <= r_s1_open;
        end
        if (w_fin_fire) begin
            r_out_cost   <= w_fin_cost;
            r_out_routes <= w_fin_routes;
        end
    end

    `VRP_ASSERT_NXT(a_visit_two_phase, r_s1_valid, r_s2_valid && !r_s1_valid)
    `VRP_ASSERT_IMP(a_no_decide_on_finish, r_s2_valid, !r_fin_pend && !w_fin_fire)
    `VRP_ASSERT_IMP(a_fire_into_free, w_fin_fire, !r_out_valid)
    `VRP_ASSERT_IMP(a_phase_blocks_input, r_s1_valid, !o_in_ready)
endmodule

FILE: tb/sv/vrp_route_split_cost_checker.sv
// Checker for the route split cost core: watches the three channels, predicts each result
// beat from its own copy of the tables and route state, and counts mismatches.
// Depends on vrp_rsc_pkg.
module vrp_route_split_cost_checker
    import vrp_rsc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [1:0]               i_cmd,
    input  logic [5:0]               i_from_node,
    input  logic [5:0]               i_to_node,
    input  logic [19:0]              i_distance_value,
    input  logic [15:0]              i_demand_value,
    input  logic [5:0]               i_customer,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [31:0]              i_total_cost,
    input  logic [6:0]               i_route_count,
    output int                       o_fail_count,
    output int                       o_pending
);
    typedef struct packed {
        logic [COST_BITS-1:0]  cost;
        logic [ROUTE_BITS-1:0] routes;
    } t_score;

    t_dist                 dist_mem [NODE_COUNT*NODE_COUNT];
    t_dem                  dem_mem [NODE_COUNT];
    t_node                 last_stop;
    t_dist                 route_len;
    t_dem                  load_left;
    t_dem                  capacity;
    logic [TIME_BITS-1:0]  time_limit;
    logic [COST_BITS-1:0]  cost_acc;
    logic [ROUTE_BITS-1:0] route_tally;
    t_score                score_q[$];
    t_score                want;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic t_dist leg(t_node a, t_node b);
        return dist_mem[int'(a) * NODE_COUNT + int'(b)];
    endfunction

    function automatic void retire_route();
        logic [COST_BITS:0] sum;
        sum = cost_acc + route_len + leg(last_stop, '0);
        cost_acc = sum[COST_BITS] ? '1 : sum[COST_BITS-1:0];
        if (route_tally != '1) begin
            route_tally = route_tally + 1'b1;
        end
        last_stop = '0;
        route_len = '0;
        load_left = capacity;
    endfunction

    function automatic void start_route(t_node c);
        route_len = leg('0, c);
        load_left = (dem_mem[c] > capacity) ? '0 : capacity - dem_mem[c];
        last_stop = c;
    endfunction

    function automatic void take_visit(t_node c);
        logic [DIST_BITS+1:0] reach;
        logic [DIST_BITS:0]   detour;
        logic [DIST_BITS:0]   extended;
        t_dist                hop;
        logic                 split;
        if (c == '0) begin
            return;
        end
        if (last_stop == '0) begin
            start_route(c);
            return;
        end
        hop = leg(last_stop, c);
        reach = route_len + hop + leg(c, '0);
        detour = leg(last_stop, '0) + leg('0, c);
        split = (reach > time_limit) || (dem_mem[c] > load_left) || (detour < hop);
        if (split) begin
            retire_route();
            start_route(c);
        end else begin
            extended = route_len + hop;
            route_len = extended[DIST_BITS] ? '1 : extended[DIST_BITS-1:0];
            load_left = load_left - dem_mem[c];
            last_stop = c;
        end
    endfunction

    function automatic t_score close_order();
        t_score s;
        if (last_stop != '0) begin
            retire_route();
        end
        s.cost = cost_acc;
        s.routes = route_tally;
        cost_acc = '0;
        route_tally = '0;
        last_stop = '0;
        route_len = '0;
        load_left = capacity;
        return s;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity = '0;
            time_limit = '1;
            last_stop = '0;
            route_len = '0;
            load_left = '0;
            cost_acc = '0;
            route_tally = '0;
            score_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_VEHICLE_CAPACITY: capacity = i_cfg_data[DEM_BITS-1:0];
                    CFG_MAX_ROUTE_TIME:   time_limit = i_cfg_data[TIME_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_cmd)
                    CMD_LOAD_DIST: begin
                        dist_mem[int'(i_from_node) * NODE_COUNT + int'(i_to_node)] =
                            i_distance_value;
                    end
                    CMD_LOAD_DEMAND: dem_mem[i_to_node] = i_demand_value;
                    CMD_VISIT:       take_visit(i_customer);
                    CMD_FINISH:      score_q.insert(score_q.size(), close_order());
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (score_q.size() == 0) begin
                    $error("result beat with none expected: total_cost %0d, route_count %0d",
                           i_total_cost, i_route_count);
                    o_fail_count++;
                end else begin
                    want = score_q.pop_front();
                    if (i_total_cost !== want.cost) begin
                        $error("total_cost: expected %0d, actual %0d", want.cost, i_total_cost);
                        o_fail_count++;
                    end
                    if (i_route_count !== want.routes) begin
                        $error("route_count: expected %0d, actual %0d",
                               want.routes, i_route_count);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = score_q.size();
    end
endmodule

FILE: tb/sv/tb.sv
// Top of the route split cost core testbench: clock, reset, stimulus and verdict.
// Depends on vrp_rsc_pkg, vrp_route_split_cost_core and vrp_route_split_cost_checker.
module tb;
    import vrp_rsc_pkg::*;

    localparam int PHASES      = 6;
    localparam int PRESS_PHASE = 4;
    localparam int DRAIN       = 12;
    localparam int MAX_MAPPED  = 20;

    localparam int CAP_PLAN [PHASES]   = '{5000, 0, 65535, 2500, 1000, 0};
    localparam int LIMIT_PLAN [PHASES] = '{1048575, 3000, 0, 8000, 1048575, 0};
    localparam int IDLE_PLAN [PHASES]  = '{0, 45, 0, 24, 0, 24};
    localparam int STALL_PLAN [PHASES] = '{0, 0, 45, 24, 0, 24};

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [1:0]               i_cmd;
    logic [5:0]               i_from_node;
    logic [5:0]               i_to_node;
    logic [19:0]              i_distance_value;
    logic [15:0]              i_demand_value;
    logic [5:0]               i_customer;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [31:0]              o_total_cost;
    logic [6:0]               o_route_count;

    int                       fail_count;
    int                       pending_scores;
    int                       sender_idle_pct;
    int                       stall_pct;
    int                       beats_sent;
    logic                     hold_active;
    logic                     press_on;
    t_node                    mapped_nodes[$];
    logic [NODE_COUNT-1:0]    mapped_mask;

    vrp_route_split_cost_core dut (.*);

    vrp_route_split_cost_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_from_node      (i_from_node),
        .i_to_node        (i_to_node),
        .i_distance_value (i_distance_value),
        .i_demand_value   (i_demand_value),
        .i_customer       (i_customer),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_total_cost     (o_total_cost),
        .i_route_count    (o_route_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending_scores)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= !hold_active && ($urandom_range(99) >= stall_pct);
        end
    end

    // The long hold-off keeps a result held until the next finish beat stalls the input.
    initial begin
        hold_active = 1'b0;
        wait (press_on === 1'b1);
        @(posedge i_clk);
        hold_active = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_active = 1'b0;
    end

    initial begin
        #2000000;
        $display("vrp_route_split_cost_core: mismatch");
        $finish;
    end

    task automatic send_item(t_cmd cmd, t_node from_n, t_node to_n, t_dist dval, t_dem dem,
                             t_node cust);
        int gap;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < sender_idle_pct) begin
            gap++;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_from_node <= from_n;
        i_to_node <= to_n;
        i_distance_value <= dval;
        i_demand_value <= dem;
        i_customer <= cust;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
    endtask

    task automatic send_leg(t_node a, t_node b, t_dist v);
        send_item(CMD_LOAD_DIST, a, b, v, t_dem'($urandom), t_node'($urandom));
    endtask

    task automatic send_demand(t_node n, t_dem v);
        send_item(CMD_LOAD_DEMAND, t_node'($urandom), n, t_dist'($urandom), v,
                  t_node'($urandom));
    endtask

    task automatic send_visit(t_node c);
        send_item(CMD_VISIT, t_node'($urandom), t_node'($urandom), t_dist'($urandom),
                  t_dem'($urandom), c);
    endtask

    task automatic send_finish();
        send_item(CMD_FINISH, t_node'($urandom), t_node'($urandom), t_dist'($urandom),
                  t_dem'($urandom), t_node'($urandom));
    endtask

    function automatic t_dist rand_leg();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3) begin
            return '0;
        end
        if (pick < 6) begin
            return '1;
        end
        if (pick < 14) begin
            return t_dist'($urandom);
        end
        return t_dist'($urandom_range(1500));
    endfunction

    function automatic t_dem rand_demand();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3) begin
            return '0;
        end
        if (pick < 6) begin
            return '1;
        end
        if (pick < 14) begin
            return t_dem'($urandom);
        end
        return t_dem'($urandom_range(600));
    endfunction

    // Every leg between a new node and the nodes already in use is written before the
    // node is visited, so no visit reads an unwritten entry.
    task automatic map_node(t_node n);
        foreach (mapped_nodes[i]) begin
            send_leg(n, mapped_nodes[i], rand_leg());
            send_leg(mapped_nodes[i], n, rand_leg());
        end
        send_leg(n, n, rand_leg());
        send_demand(n, rand_demand());
        mapped_nodes.insert(mapped_nodes.size(), n);
        mapped_mask[n] = 1'b1;
    endtask

    task automatic noise_load();
        if ($urandom_range(1) == 0) begin
            send_leg(t_node'($urandom), t_node'($urandom), rand_leg());
        end else begin
            send_demand(t_node'($urandom), rand_demand());
        end
    endtask

    task automatic run_order(int max_visits);
        t_node n;
        int    visits;
        int    pick;
        if (mapped_nodes.size() < MAX_MAPPED && $urandom_range(99) < 12) begin
            do n = t_node'($urandom_range(1, NODE_COUNT - 1)); while (mapped_mask[n]);
            map_node(n);
        end
        repeat ($urandom_range(0, 2)) noise_load();
        visits = $urandom_range(0, max_visits);
        repeat (visits) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                noise_load();
            end else if (pick < 7) begin
                send_visit('0);
            end else begin
                send_visit(mapped_nodes[$urandom_range(1, mapped_nodes.size() - 1)]);
            end
        end
        send_finish();
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_scores != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);
    endtask

    initial begin
        int cap;
        int limit;
        int target;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_cmd = CMD_LOAD_DIST;
        i_from_node = '0;
        i_to_node = '0;
        i_distance_value = '0;
        i_demand_value = '0;
        i_customer = '0;
        sender_idle_pct = 0;
        stall_pct = 0;
        beats_sent = 0;
        press_on = 1'b0;
        mapped_mask = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset register values: a capacity of zero and the
        // longest route time.
        send_leg(0, 0, '0);
        send_leg(0, 1, 10);
        send_leg(1, 0, 10);
        send_leg(0, 63, 20);
        send_leg(63, 0, 20);
        send_leg(1, 63, 50);
        send_leg(63, 1, 5);
        send_leg(1, 1, '0);
        send_leg(63, 63, '1);
        send_demand(0, '0);
        send_demand(1, '1);
        send_demand(63, 3);
        send_finish();
        send_visit(1);
        send_visit(63);
        send_visit(1);
        send_visit(0);
        send_visit(63);
        send_visit(63);
        send_finish();
        mapped_nodes = '{0, 1, 63};
        mapped_mask[0] = 1'b1;
        mapped_mask[1] = 1'b1;
        mapped_mask[63] = 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            settle();
            cap = (p == PHASES - 1) ? $urandom_range(65535) : CAP_PLAN[p];
            limit = (p == PHASES - 1) ? $urandom_range(500, 12000) : LIMIT_PLAN[p];
            write_reg(CFG_VEHICLE_CAPACITY, {4'($urandom), 16'(cap)});
            write_reg(CFG_MAX_ROUTE_TIME, 20'(limit));
            sender_idle_pct = IDLE_PLAN[p];
            stall_pct = STALL_PLAN[p];
            if (p == PRESS_PHASE) begin
                press_on = 1'b1;
            end
            target = beats_sent + ((p == PRESS_PHASE) ? 150 : 360);
            while (beats_sent < target) begin
                run_order((p == PRESS_PHASE) ? 2 : 10);
            end
        end
        settle();
        if (fail_count == 0) begin
            $display("vrp_route_split_cost_core: match");
        end else begin
            $display("vrp_route_split_cost_core: mismatch");
        end
        $finish;
    end
endmodule

FILE: vrp_route_split_cost_core.f
+incdir+hdl
hdl/vrp_rsc_pkg.sv
hdl/vrp_rsc_dist_mem.sv
hdl/vrp_rsc_dem_mem.sv
hdl/vrp_rsc_eval.sv
hdl/vrp_route_split_cost_core.sv
tb/sv/vrp_route_split_cost_checker.sv
tb/sv/tb.sv
